>>> sv/bst_pkg.sv
// shared types, token codes and character classes for the byte stream tokenizer
package bst_pkg;

	// input item and result item as seen on the ports
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_marker;
	} src_item_t;

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       token_done;
		logic       step_last;
	} token_item_t;

	// one result without its step_last flag
	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       token_done;
	} res_t;

	// all results caused by one input item; two set means both slots are used
	typedef struct packed {
		logic       two;
		res_t [1:0] r;
	} bundle_t;

	// scanner modes
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_WORD,
		MODE_SLASH,
		MODE_COMMENT,
		MODE_STR,
		MODE_CH1,
		MODE_CH2
	} mode_t;

	// token kinds
	localparam logic [4:0] KIND_NUMBER     = 5'd0;
	localparam logic [4:0] KIND_KW_INT     = 5'd1;
	localparam logic [4:0] KIND_KW_UINT    = 5'd2;
	localparam logic [4:0] KIND_KW_SHORT   = 5'd3;
	localparam logic [4:0] KIND_KW_LONG    = 5'd4;
	localparam logic [4:0] KIND_KW_FLOAT   = 5'd5;
	localparam logic [4:0] KIND_KW_DOUBLE  = 5'd6;
	localparam logic [4:0] KIND_KW_BOOL    = 5'd7;
	localparam logic [4:0] KIND_KW_STRING  = 5'd8;
	localparam logic [4:0] KIND_KW_CHAR    = 5'd9;
	localparam logic [4:0] KIND_KW_LET     = 5'd10;
	localparam logic [4:0] KIND_IDENT      = 5'd11;
	localparam logic [4:0] KIND_PLUS       = 5'd12;
	localparam logic [4:0] KIND_MINUS      = 5'd13;
	localparam logic [4:0] KIND_STAR       = 5'd14;
	localparam logic [4:0] KIND_SLASH      = 5'd15;
	localparam logic [4:0] KIND_LPAREN     = 5'd16;
	localparam logic [4:0] KIND_RPAREN     = 5'd17;
	localparam logic [4:0] KIND_LBRACE     = 5'd18;
	localparam logic [4:0] KIND_RBRACE     = 5'd19;
	localparam logic [4:0] KIND_SEMI       = 5'd20;
	localparam logic [4:0] KIND_STR_LIT    = 5'd21;
	localparam logic [4:0] KIND_CHAR_LIT   = 5'd22;
	localparam logic [4:0] KIND_EQUAL      = 5'd23;
	localparam logic [4:0] KIND_INVALID    = 5'd24;
	localparam logic [4:0] KIND_END        = 5'd25;
	localparam logic [4:0] KIND_ERR_DOT    = 5'd26;
	localparam logic [4:0] KIND_ERR_STR    = 5'd27;
	localparam logic [4:0] KIND_ERR_CHAR   = 5'd28;

	// characters with a meaning of their own
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// keyword text, first byte in the low lane
	localparam logic [47:0] KW_INT    = 48'h000000746E69;
	localparam logic [47:0] KW_UINT   = 48'h0000746E6975;
	localparam logic [47:0] KW_SHORT  = 48'h0074726F6873;
	localparam logic [47:0] KW_LONG   = 48'h0000676E6F6C;
	localparam logic [47:0] KW_FLOAT  = 48'h0074616F6C66;
	localparam logic [47:0] KW_DOUBLE = 48'h656C62756F64;
	localparam logic [47:0] KW_BOOL   = 48'h00006C6F6F62;
	localparam logic [47:0] KW_STRING = 48'h676E69727473;
	localparam logic [47:0] KW_CHAR   = 48'h000072616863;
	localparam logic [47:0] KW_LET    = 48'h00000074656C;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			(c == CH_USCORE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// kind of a single-character token, invalid when none matches
	function automatic logic [4:0] sym_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_STAR;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_SEMI:   k = KIND_SEMI;
			CH_EQUAL:  k = KIND_EQUAL;
			default:   k = KIND_INVALID;
		endcase
		return k;
	endfunction

	// final kind of a word from its first six bytes and its saturated length
	function automatic logic [4:0] kw_kind(input logic [47:0] p, input logic [2:0] n);
		logic [4:0] k;
		k = KIND_IDENT;
		if (n == 3'd3 && p == KW_INT)    k = KIND_KW_INT;
		if (n == 3'd4 && p == KW_UINT)   k = KIND_KW_UINT;
		if (n == 3'd5 && p == KW_SHORT)  k = KIND_KW_SHORT;
		if (n == 3'd4 && p == KW_LONG)   k = KIND_KW_LONG;
		if (n == 3'd5 && p == KW_FLOAT)  k = KIND_KW_FLOAT;
		if (n == 3'd6 && p == KW_DOUBLE) k = KIND_KW_DOUBLE;
		if (n == 3'd4 && p == KW_BOOL)   k = KIND_KW_BOOL;
		if (n == 3'd6 && p == KW_STRING) k = KIND_KW_STRING;
		if (n == 3'd4 && p == KW_CHAR)   k = KIND_KW_CHAR;
		if (n == 3'd3 && p == KW_LET)    k = KIND_KW_LET;
		return k;
	endfunction

endpackage

>>> sv/byte_stream_tokenizer.sv
// top level of the byte stream tokenizer: scanner, bundle queue and output stage
//
//   channel   direction  handshake            payload
//   src       in         push / full          src_item_t  (char_byte, end_marker)
//   token     out        empty / pop          token_item_t (kind, text_byte, byte_valid,
//                                                          token_done, step_last)
//
// one byte is accepted per cycle unless full; its results are decided in that same cycle
// a result goes through the bundle queue and the output register to the token port
// the output stage shows one result at a time; an item may cause up to two results
// the bundle queue holds Depth bundles; full rises when pop stalls or when
// two-result items arrive faster than the output drains them
// arst_n returns the scanner to idle and empties queue and output stage
module byte_stream_tokenizer import bst_pkg::*; #(
	parameter int Depth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  src_item_t   src,
	output logic        empty,
	input  logic        pop,
	output token_item_t token
);

	localparam int BundleW = $bits(bundle_t);

	logic         wr, rd, fifo_full, nonempty;
	bundle_t      wr_data, head;
	logic [BundleW-1:0] head_bits;

	assign full = fifo_full;
	assign head = bundle_t'(head_bits);

	// scanner
	bst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.src       (src),
		.fifo_full (fifo_full),
		.wr        (wr),
		.wr_data   (wr_data)
	);

	// bundle queue
	bst_fifo #(
		.Width (BundleW),
		.Depth (Depth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_data  (BundleW'(wr_data)),
		.full     (fifo_full),
		.rd       (rd),
		.rd_data  (head_bits),
		.nonempty (nonempty)
	);

	// output stage
	bst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (nonempty),
		.take       (rd),
		.empty      (empty),
		.pop        (pop),
		.token      (token)
	);

endmodule

>>> sv/bst_front.sv
// front end: scanner state machine that turns each byte into a bundle of results
module bst_front import bst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  src_item_t src,
	input  logic      fifo_full,
	output logic      wr,
	output bundle_t   wr_data
);

	mode_t       mode_q, mode_d;
	logic [7:0]  prev_q, prev_d;
	logic        at_start_q, at_start_d;
	logic        seen_dot_q, seen_dot_d;
	logic [47:0] prefix_q, prefix_d;
	logic [2:0]  wlen_q, wlen_d;

	logic       accept;
	logic [7:0] c;
	logic       c_dig, c_let, c_sp, c_dot;
	logic       num_start, fresh;
	mode_t      fresh_mode;
	res_t       close_r, fresh_r;
	logic       close_v, fresh_v;

	assign accept = push && !fifo_full;
	assign c      = src.char_byte;

	// character classes
	assign c_dig = is_digit(c);
	assign c_let = is_letter(c);
	assign c_sp  = is_space(c);
	assign c_dot = (c == CH_DOT);

	assign num_start = c_dig || c_dot ||
		(c == CH_MINUS && (at_start_q || prev_q == CH_LPAREN || prev_q == CH_PLUS ||
			prev_q == CH_MINUS)) ||
		(c == CH_PLUS && (at_start_q || prev_q == CH_LPAREN));

	// byte that ends the current token and gets scanned again from idle
	always_comb begin
		fresh = 1'b0;
		if (!src.end_marker) begin
			case (mode_q)
				MODE_IDLE:  fresh = 1'b1;
				MODE_NUM:   fresh = !c_dig && !c_dot;
				MODE_WORD:  fresh = !c_let;
				MODE_SLASH: fresh = (c != CH_SLASH);
				default:    fresh = 1'b0;
			endcase
		end
	end

	// mode entered by a byte scanned from idle
	always_comb begin
		if (c_sp)
			fresh_mode = MODE_IDLE;
		else if (num_start)
			fresh_mode = MODE_NUM;
		else if (c_let)
			fresh_mode = MODE_WORD;
		else if (c == CH_SLASH)
			fresh_mode = MODE_SLASH;
		else if (c == CH_DQUOTE)
			fresh_mode = MODE_STR;
		else if (c == CH_SQUOTE)
			fresh_mode = MODE_CH1;
		else
			fresh_mode = MODE_IDLE;
	end

	// next state
	always_comb begin
		mode_d     = mode_q;
		prev_d     = prev_q;
		at_start_d = at_start_q;
		seen_dot_d = seen_dot_q;
		prefix_d   = prefix_q;
		wlen_d     = wlen_q;
		if (src.end_marker) begin
			mode_d     = MODE_IDLE;
			prev_d     = '0;
			at_start_d = 1'b1;
			seen_dot_d = 1'b0;
			prefix_d   = '0;
			wlen_d     = '0;
		end else begin
			prev_d     = c;
			at_start_d = 1'b0;
			case (mode_q)
				MODE_NUM: begin
					if (!c_dig && c_dot) begin
						if (seen_dot_q)
							mode_d = MODE_IDLE;
						else
							seen_dot_d = 1'b1;
					end
				end
				MODE_WORD: begin
					if (c_let) begin
						if (wlen_q < 3'd6) begin
							for (int i = 0; i < 6; i++)
								if (wlen_q == 3'(i))
									prefix_d[8*i +: 8] = c;
							wlen_d = wlen_q + 3'd1;
						end else begin
							wlen_d = 3'd7;
						end
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH)
						mode_d = MODE_COMMENT;
				end
				MODE_COMMENT: begin
					if (c == CH_LF)
						mode_d = MODE_IDLE;
				end
				MODE_STR: begin
					if (c == CH_DQUOTE)
						mode_d = MODE_IDLE;
				end
				MODE_CH1: mode_d = MODE_CH2;
				MODE_CH2: mode_d = MODE_IDLE;
				default:  mode_d = mode_q;
			endcase
			if (fresh) begin
				mode_d = fresh_mode;
				if (!c_sp && num_start)
					seen_dot_d = c_dot;
				else if (!c_sp && c_let) begin
					prefix_d = {40'd0, c};
					wlen_d   = 3'd1;
				end
			end
		end
	end

	// result from the current token: its close, a text byte or an error
	always_comb begin
		close_v = 1'b0;
		close_r = '0;
		if (src.end_marker) begin
			case (mode_q)
				MODE_NUM: begin
					close_v = 1'b1;
					close_r = '{KIND_NUMBER, 8'd0, 1'b0, 1'b1};
				end
				MODE_WORD: begin
					close_v = 1'b1;
					close_r = '{kw_kind(prefix_q, wlen_q), 8'd0, 1'b0, 1'b1};
				end
				MODE_SLASH: begin
					close_v = 1'b1;
					close_r = '{KIND_SLASH, CH_SLASH, 1'b1, 1'b1};
				end
				MODE_STR: begin
					close_v = 1'b1;
					close_r = '{KIND_ERR_STR, 8'd0, 1'b0, 1'b1};
				end
				MODE_CH1, MODE_CH2: begin
					close_v = 1'b1;
					close_r = '{KIND_ERR_CHAR, 8'd0, 1'b0, 1'b1};
				end
				default: close_v = 1'b0;
			endcase
		end else begin
			case (mode_q)
				MODE_NUM: begin
					close_v = 1'b1;
					if (c_dig)
						close_r = '{KIND_NUMBER, c, 1'b1, 1'b0};
					else if (c_dot && seen_dot_q)
						close_r = '{KIND_ERR_DOT, 8'd0, 1'b0, 1'b1};
					else if (c_dot)
						close_r = '{KIND_NUMBER, c, 1'b1, 1'b0};
					else
						close_r = '{KIND_NUMBER, 8'd0, 1'b0, 1'b1};
				end
				MODE_WORD: begin
					close_v = 1'b1;
					if (c_let)
						close_r = '{KIND_IDENT, c, 1'b1, 1'b0};
					else
						close_r = '{kw_kind(prefix_q, wlen_q), 8'd0, 1'b0, 1'b1};
				end
				MODE_SLASH: begin
					close_v = (c != CH_SLASH);
					close_r = '{KIND_SLASH, CH_SLASH, 1'b1, 1'b1};
				end
				MODE_STR: begin
					close_v = 1'b1;
					if (c == CH_DQUOTE)
						close_r = '{KIND_STR_LIT, 8'd0, 1'b0, 1'b1};
					else
						close_r = '{KIND_STR_LIT, c, 1'b1, 1'b0};
				end
				MODE_CH1: begin
					close_v = 1'b1;
					close_r = '{KIND_CHAR_LIT, c, 1'b1, 1'b0};
				end
				MODE_CH2: begin
					close_v = 1'b1;
					close_r = '{(c == CH_SQUOTE) ? KIND_CHAR_LIT : KIND_ERR_CHAR,
						8'd0, 1'b0, 1'b1};
				end
				default: close_v = 1'b0;
			endcase
		end
	end

	// result from the byte scanned afresh, or the end item
	always_comb begin
		fresh_v = 1'b0;
		fresh_r = '0;
		if (src.end_marker) begin
			fresh_v = 1'b1;
			fresh_r = '{KIND_END, 8'd0, 1'b0, 1'b1};
		end else if (fresh && !c_sp) begin
			if (num_start) begin
				fresh_v = 1'b1;
				fresh_r = '{KIND_NUMBER, c, 1'b1, 1'b0};
			end else if (c_let) begin
				fresh_v = 1'b1;
				fresh_r = '{KIND_IDENT, c, 1'b1, 1'b0};
			end else if (c != CH_SLASH && c != CH_DQUOTE && c != CH_SQUOTE) begin
				fresh_v = 1'b1;
				fresh_r = '{sym_kind(c), c, 1'b1, 1'b1};
			end
		end
	end

	// pack the results of this item, oldest in slot zero
	always_comb begin
		wr_data = '0;
		if (close_v) begin
			wr_data.r[0] = close_r;
			wr_data.r[1] = fresh_r;
			wr_data.two  = fresh_v;
		end else begin
			wr_data.r[0] = fresh_r;
		end
	end

	assign wr = accept && (close_v || fresh_v);

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			prev_q     <= '0;
			at_start_q <= 1'b1;
			seen_dot_q <= 1'b0;
			prefix_q   <= '0;
			wlen_q     <= '0;
		end else if (accept) begin
			mode_q     <= mode_d;
			prev_q     <= prev_d;
			at_start_q <= at_start_d;
			seen_dot_q <= seen_dot_d;
			prefix_q   <= prefix_d;
			wlen_q     <= wlen_d;
		end
	end

`ifndef NO_ASSERTIONS
	// an end marker leaves the scanner as after reset
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && src.end_marker) |=> (mode_q == MODE_IDLE && at_start_q && wlen_q == 3'd0))
		else $error("end marker did not return scanner to idle");

	// an end marker always yields at least the end item
	a_end_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && src.end_marker) |-> wr)
		else $error("end marker produced no result");
`endif

endmodule

>>> sv/bst_fifo.sv
// small register queue of result bundles between front and back
module bst_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [Width-1:0] wr_data,
	output logic             full,
	input  logic             rd,
	output logic [Width-1:0] rd_data,
	output logic             nonempty
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wptr_q, rptr_q;
	logic [CntW-1:0]  cnt_q;

	assign full     = (cnt_q == CntW'(Depth));
	assign nonempty = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	// writer respects full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full)
		else $error("queue written while full");

	// reader respects empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> nonempty)
		else $error("queue read while empty");
`endif

endmodule

>>> sv/bst_back.sv
// back end: output register that hands out the results of a bundle one at a time
module bst_back import bst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     head,
	input  logic        head_valid,
	output logic        take,
	output logic        empty,
	input  logic        pop,
	output token_item_t token
);

	bundle_t cur_q;
	logic    idx_q;
	logic    valid_q;
	logic    advance, last;
	res_t    sel;

	assign advance = pop && valid_q;
	assign last    = idx_q || !cur_q.two;
	assign take    = head_valid && (!valid_q || (advance && last));
	assign empty   = !valid_q;

	// result on the ports
	assign sel   = cur_q.r[idx_q];
	assign token = '{sel.kind, sel.text_byte, sel.byte_valid, sel.token_done, last};

	// bundle payload
	always_ff @(posedge clk) begin
		if (take)
			cur_q <= head;
	end

	// slot index and holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= 1'b0;
		end else if (advance && last) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (advance) begin
			idx_q <= 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	// second slot is only shown for a bundle that has one
	a_idx_two: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (valid_q && cur_q.two))
		else $error("second slot selected on a single-result bundle");

	// a loaded bundle is offered in the next cycle
	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (!empty && !idx_q))
		else $error("loaded bundle not offered");
`endif

endmodule

>>> test/byte_stream_tokenizer_check.sv
`timescale 1ns / 1ps
// checker for the byte stream tokenizer: lexes accepted bytes and compares the token stream
module byte_stream_tokenizer_check import bst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  src_item_t   src,
	input  logic        empty,
	input  logic        pop,
	input  token_item_t token,
	output int          mismatches,
	output int          outstanding
);

	// keyword spellings and the kinds they map to
	string keyword_text [10] = '{"int", "uint", "short", "long", "float",
		"double", "bool", "string", "char", "let"};
	logic [4:0] keyword_code [10] = '{KIND_KW_INT, KIND_KW_UINT, KIND_KW_SHORT,
		KIND_KW_LONG, KIND_KW_FLOAT, KIND_KW_DOUBLE, KIND_KW_BOOL, KIND_KW_STRING,
		KIND_KW_CHAR, KIND_KW_LET};

	// lexer state
	mode_t       mode;
	logic [7:0]  last_byte;
	logic        first_byte;
	logic        dot_seen;
	logic [47:0] word_head;
	logic [2:0]  word_len;

	// tokens caused by the current byte, and tokens still to come out
	token_item_t step_tokens[$];
	token_item_t token_q[$];
	int          fail_count = 0;

	function automatic logic digit_c(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter_c(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCORE;
	endfunction

	function automatic logic space_c(input logic [7:0] c);
		return c == " " || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void clear_scan();
		mode       = MODE_IDLE;
		last_byte  = 8'h00;
		first_byte = 1'b1;
		dot_seen   = 1'b0;
		word_head  = '0;
		word_len   = 3'd0;
	endfunction

	function automatic void emit(input logic [4:0] k, input logic [7:0] b, input logic v,
			input logic d);
		token_item_t t;
		t.kind       = k;
		t.text_byte  = b;
		t.byte_valid = v;
		t.token_done = d;
		t.step_last  = 1'b0;
		if (step_tokens.size() < 3) step_tokens.push_back(t);
	endfunction

	// final kind of the current word: keyword when its length and prefix match
	function automatic logic [4:0] word_kind();
		logic [47:0] kw_bits;
		int          n;
		int          k;
		word_kind = KIND_IDENT;
		for (k = 0; k < 10; k++) begin
			kw_bits = '0;
			n = 0;
			while (n < 6 && n < keyword_text[k].len()) begin
				kw_bits[8*n +: 8] = keyword_text[k][n];
				n++;
			end
			if (word_kind == KIND_IDENT && word_len == n && word_head == kw_bits)
				word_kind = keyword_code[k];
		end
	endfunction

	// start a new token from idle
	function automatic void scan_afresh(input logic [7:0] c);
		mode = MODE_IDLE;
		if (space_c(c)) begin
		end else if (digit_c(c) || c == CH_DOT ||
				(c == CH_MINUS && (first_byte || last_byte == CH_LPAREN ||
				last_byte == CH_PLUS || last_byte == CH_MINUS)) ||
				(c == CH_PLUS && (first_byte || last_byte == CH_LPAREN))) begin
			mode     = MODE_NUM;
			dot_seen = (c == CH_DOT);
			emit(KIND_NUMBER, c, 1'b1, 1'b0);
		end else if (letter_c(c)) begin
			mode      = MODE_WORD;
			word_head = {40'd0, c};
			word_len  = 3'd1;
			emit(KIND_IDENT, c, 1'b1, 1'b0);
		end else begin
			case (c)
				CH_PLUS:   emit(KIND_PLUS, c, 1'b1, 1'b1);
				CH_MINUS:  emit(KIND_MINUS, c, 1'b1, 1'b1);
				CH_STAR:   emit(KIND_STAR, c, 1'b1, 1'b1);
				CH_LPAREN: emit(KIND_LPAREN, c, 1'b1, 1'b1);
				CH_RPAREN: emit(KIND_RPAREN, c, 1'b1, 1'b1);
				CH_LBRACE: emit(KIND_LBRACE, c, 1'b1, 1'b1);
				CH_RBRACE: emit(KIND_RBRACE, c, 1'b1, 1'b1);
				CH_SEMI:   emit(KIND_SEMI, c, 1'b1, 1'b1);
				CH_EQUAL:  emit(KIND_EQUAL, c, 1'b1, 1'b1);
				CH_SLASH:  mode = MODE_SLASH;
				CH_DQUOTE: mode = MODE_STR;
				CH_SQUOTE: mode = MODE_CH1;
				default:   emit(KIND_INVALID, c, 1'b1, 1'b1);
			endcase
		end
	endfunction

	// lex one accepted item and queue the tokens it causes
	function automatic void lex_item(input src_item_t it);
		logic [7:0] c;
		logic       rescan;
		c = it.char_byte;
		rescan = 1'b0;
		step_tokens.delete();
		if (it.end_marker) begin
			// close whatever is open, then the end token
			case (mode)
				MODE_NUM:           emit(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
				MODE_WORD:          emit(word_kind(), 8'h00, 1'b0, 1'b1);
				MODE_SLASH:         emit(KIND_SLASH, CH_SLASH, 1'b1, 1'b1);
				MODE_STR:           emit(KIND_ERR_STR, 8'h00, 1'b0, 1'b1);
				MODE_CH1, MODE_CH2: emit(KIND_ERR_CHAR, 8'h00, 1'b0, 1'b1);
				default: ;
			endcase
			emit(KIND_END, 8'h00, 1'b0, 1'b1);
			clear_scan();
		end else begin
			case (mode)
				MODE_NUM: begin
					if (digit_c(c)) begin
						emit(KIND_NUMBER, c, 1'b1, 1'b0);
					end else if (c == CH_DOT) begin
						if (dot_seen) begin
							emit(KIND_ERR_DOT, 8'h00, 1'b0, 1'b1);
							mode = MODE_IDLE;
						end else begin
							dot_seen = 1'b1;
							emit(KIND_NUMBER, c, 1'b1, 1'b0);
						end
					end else begin
						emit(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
						rescan = 1'b1;
					end
				end
				MODE_WORD: begin
					if (letter_c(c)) begin
						if (word_len < 3'd6) begin
							word_head[8*word_len +: 8] = c;
							word_len = word_len + 3'd1;
						end else begin
							word_len = 3'd7;
						end
						emit(KIND_IDENT, c, 1'b1, 1'b0);
					end else begin
						emit(word_kind(), 8'h00, 1'b0, 1'b1);
						rescan = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (c == CH_SLASH) begin
						mode = MODE_COMMENT;
					end else begin
						emit(KIND_SLASH, CH_SLASH, 1'b1, 1'b1);
						rescan = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_LF) mode = MODE_IDLE;
				end
				MODE_STR: begin
					if (c == CH_DQUOTE) begin
						emit(KIND_STR_LIT, 8'h00, 1'b0, 1'b1);
						mode = MODE_IDLE;
					end else begin
						emit(KIND_STR_LIT, c, 1'b1, 1'b0);
					end
				end
				MODE_CH1: begin
					emit(KIND_CHAR_LIT, c, 1'b1, 1'b0);
					mode = MODE_CH2;
				end
				MODE_CH2: begin
					emit(c == CH_SQUOTE ? KIND_CHAR_LIT : KIND_ERR_CHAR, 8'h00, 1'b0, 1'b1);
					mode = MODE_IDLE;
				end
				default: rescan = 1'b1;
			endcase
			if (rescan) scan_afresh(c);
			last_byte  = c;
			first_byte = 1'b0;
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].step_last = 1'b1;
		foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
	endfunction

	function automatic void report(input string what, input token_item_t want,
			input token_item_t got);
		string want_s;
		string got_s;
		fail_count++;
		if (fail_count <= 10) begin
			want_s = $sformatf("kind %0d byte %02h valid %b done %b last %b",
				want.kind, want.text_byte, want.byte_valid, want.token_done, want.step_last);
			got_s = $sformatf("kind %0d byte %02h valid %b done %b last %b",
				got.kind, got.text_byte, got.byte_valid, got.token_done, got.step_last);
			$display("%s: expected %s, got %s", what, want_s, got_s);
		end
	endfunction

	// compare one popped item with the oldest expected token
	function automatic void check_token(input token_item_t got);
		token_item_t want;
		if (token_q.size() == 0) begin
			report("unexpected token", '0, got);
		end else begin
			want = token_q.pop_front();
			if (got.kind !== want.kind || got.text_byte !== want.text_byte ||
					got.byte_valid !== want.byte_valid ||
					got.token_done !== want.token_done || got.step_last !== want.step_last)
				report("token mismatch", want, got);
		end
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			token_q.delete();
		end else begin
			if (push && !full) lex_item(src);
			if (pop && !empty) check_token(token);
		end
		outstanding <= token_q.size();
		mismatches  <= fail_count;
	end

endmodule

>>> test/byte_stream_tokenizer_test.sv
`timescale 1ns / 1ps
// testbench top for the byte stream tokenizer: source text stimulus, pop stalls and verdict
module byte_stream_tokenizer_test import bst_pkg::*; ();

	localparam int CycleLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	src_item_t   src = '0;
	logic        empty;
	logic        pop = 1'b0;
	token_item_t token;
	int          mismatches;
	int          outstanding;
	int          cycles = 0;
	int          pop_hold = 0;
	int          pop_run = 0;
	int          burst_left = 0;

	src_item_t   text_q[$];
	string       keywords [10] = '{"int", "uint", "short", "long", "float",
		"double", "bool", "string", "char", "let"};
	string       operators = "+-*/(){};=";
	string       blanks = " \t\n\013\014\r";

	byte_stream_tokenizer i_dut (
		.clk, .arst_n, .push, .full, .src, .empty, .pop, .token
	);

	byte_stream_tokenizer_check i_check (
		.clk, .arst_n, .push, .full, .src, .empty, .pop, .token,
		.mismatches, .outstanding
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("byte_stream_tokenizer: mismatch");
			$finish;
		end
	end

	// gap length: mostly short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14) return $urandom_range(1, 3);
		if (r < 18) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// pop with random stalls and stall-free runs
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if (pop_run > 0) pop_run <= pop_run - 1;
			else if ($urandom_range(0, 9) == 0) pop_run <= $urandom_range(20, 60);
			else if ($urandom_range(0, 2) == 0) pop_hold <= idle_len();
		end
	end

	function automatic void put_byte(input logic [7:0] b);
		src_item_t it;
		it.char_byte  = b;
		it.end_marker = 1'b0;
		text_q.push_back(it);
	endfunction

	function automatic void put_end();
		src_item_t it;
		it.char_byte  = 8'($urandom_range(0, 255));
		it.end_marker = 1'b1;
		text_q.push_back(it);
	endfunction

	function automatic void put_text(input string s);
		foreach (s[i]) put_byte(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		return CH_USCORE;
	endfunction

	function automatic logic [7:0] rand_byte_but(input logic [7:0] skip);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == skip);
		return b;
	endfunction

	// one random token, mostly well formed
	function automatic void add_token();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			// keyword, sometimes stretched into an identifier
			put_text(keywords[$urandom_range(0, 9)]);
			if ($urandom_range(0, 4) == 0) put_byte(rand_letter());
		end else if (r < 28) begin
			n = $urandom_range(1, 9);
			repeat (n) put_byte(rand_letter());
		end else if (r < 43) begin
			// number, maybe signed, maybe with up to three dots
			if ($urandom_range(0, 3) == 0) put_byte(CH_LPAREN);
			if ($urandom_range(0, 2) == 0) put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
			if ($urandom_range(0, 5) == 0) put_byte(CH_DOT);
			n = $urandom_range(1, 4);
			repeat (n) put_byte(8'("0" + $urandom_range(0, 9)));
			if ($urandom_range(0, 2) == 0) begin
				put_byte(CH_DOT);
				put_byte(8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 5) == 0) put_byte(CH_DOT);
			end
		end else if (r < 53) begin
			put_byte(operators[$urandom_range(0, operators.len() - 1)]);
		end else if (r < 63) begin
			// string literal, sometimes left open
			put_byte(CH_DQUOTE);
			n = $urandom_range(0, 5);
			repeat (n) put_byte(rand_byte_but(CH_DQUOTE));
			if ($urandom_range(0, 9) != 0) put_byte(CH_DQUOTE);
		end else if (r < 71) begin
			// char literal, sometimes badly closed
			put_byte(CH_SQUOTE);
			put_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 6) != 0) put_byte(CH_SQUOTE);
			else put_byte(rand_byte_but(CH_SQUOTE));
		end else if (r < 77) begin
			put_byte(CH_SLASH);
			put_byte(CH_SLASH);
			n = $urandom_range(0, 5);
			repeat (n) put_byte(rand_byte_but(CH_LF));
			put_byte(CH_LF);
		end else if (r < 85) begin
			put_byte(blanks[$urandom_range(0, blanks.len() - 1)]);
		end else begin
			put_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void build_stimulus();
		int n;
		// directed: keyword, sign rules, second dot, char literal, lone slash,
		// comment, high byte, string left open at the end, leading plus number
		put_text("int v=-1.2.'c'/ //\n");
		put_byte(8'hFF);
		put_text("\"s");
		put_end();
		put_text("+9");
		put_end();
		// random texts
		while (text_q.size() < 205) begin
			n = $urandom_range(3, 12);
			repeat (n) begin
				add_token();
				if ($urandom_range(0, 1) == 0) put_byte(" ");
			end
			put_end();
		end
	endfunction

	// stimulus and verdict
	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (text_q[i]) begin
			src  <= text_q[i];
			push <= 1'b1;
			@(posedge clk);
			while (full) @(posedge clk);
			if (burst_left > 0) begin
				burst_left--;
			end else if ($urandom_range(0, 19) == 0) begin
				burst_left = $urandom_range(15, 40);
			end else if ($urandom_range(0, 2) == 0) begin
				push <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
		end
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("byte_stream_tokenizer: match");
		end else begin
			$display("byte_stream_tokenizer: mismatch");
		end
		$finish;
	end

endmodule

>>> files.f
sv/bst_pkg.sv
sv/bst_front.sv
sv/bst_fifo.sv
sv/bst_back.sv
sv/byte_stream_tokenizer.sv
test/byte_stream_tokenizer_check.sv
test/byte_stream_tokenizer_test.sv
